### sv/b64dec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64dec_pkg
// Shared types, constants and the alphabet lookup for the base64 decoder.
// ----------------------------------------------------------------------------
package b64dec_pkg;

	// The pad character that stops decoding for the rest of a message.
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// Default number of entries in the queue between front and back.
	localparam int QUEUE_DEPTH_DEF = 4;

	// One looked-up character: a valid flag and its 6-bit value.
	typedef struct packed {
		logic       valid;
		logic [5:0] value;
	} sextet_t;

	// One queue entry: up to three bytes, most significant first.
	// A byte count of zero stands for the empty end marker.
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      n_bytes;
		logic            msg_end;
	} group_t;

	// Map a character over the standard alphabet.
	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t s;
		s.valid = 1'b1;
		s.value = 6'd0;
		case (c) inside
			[8'h41:8'h5A]: s.value = 6'(c - 8'h41);
			[8'h61:8'h7A]: s.value = 6'(c - 8'h61 + 8'd26);
			[8'h30:8'h39]: s.value = 6'(c - 8'h30 + 8'd52);
			8'h2B:         s.value = 6'd62;
			8'h2F:         s.value = 6'd63;
			default:       s.valid = 1'b0;
		endcase
		return s;
	endfunction

endpackage

### sv/b64dec_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64dec_if
// Valid/ready channels for input characters and decoded bytes.
// ----------------------------------------------------------------------------
interface b64dec_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, char_code, last_char, input ready);
	modport sink   (input valid, char_code, last_char, output ready);
endinterface

interface b64dec_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_data;
	logic       run_last;
	logic       message_end;

	modport source (output valid, data_byte, has_data, run_last, message_end, input ready);
	modport sink   (input valid, data_byte, has_data, run_last, message_end, output ready);
endinterface

### sv/base64_stream_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Base64 decoder over a character stream, one result byte per transfer.
//
// Usage: characters enter on in_ch (char_code, last_char marks the final
// character of a message). Decoded bytes leave on out_ch with has_data,
// run_last and message_end. A message with no bytes left at its end gives
// one empty end marker (has_data low).
// Throughput: one character per cycle while the queue has room; the
// output sends one result per cycle while the receiver is ready, so a
// four-character group that yields three bytes uses three output
// transfers. The group queue (QUEUE_DEPTH entries) absorbs these
// bursts; when it is full, in_ch.ready drops.
// Each result is held in a queue entry, then in the output stage register.
// Reset clears the gather state, the queue and the output stage. When the
// receiver stalls, the current result holds and the queue fills, then the
// input stalls as well.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top #(
	parameter int QUEUE_DEPTH = b64dec_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	b64dec_char_if.sink   in_ch,
	b64dec_byte_if.source out_ch
);
	import b64dec_pkg::*;

	logic   q_full;
	logic   q_not_empty;
	logic   push;
	logic   pop;
	group_t push_data;
	group_t q_head;

	// Front: classification and sextet gathering.
	b64dec_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	// Queue of byte groups.
	b64dec_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// Back: serializes each group onto the output channel.
	b64dec_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (pop),
		.out_ch      (out_ch)
	);

endmodule

### sv/b64dec_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64dec_front
// Accepts characters, gathers sextets and pushes byte groups to the queue.
// ----------------------------------------------------------------------------
module b64dec_front (
	input  logic                   clk,
	input  logic                   arst_n,
	b64dec_char_if.sink            in_ch,
	input  logic                   q_full,
	output logic                   push,
	output b64dec_pkg::group_t     push_data
);
	import b64dec_pkg::*;

	logic [17:0] buf_q;
	logic [1:0]  cnt_q;
	logic        pad_q;

	sextet_t     sx;
	logic        is_pad;
	logic        take;
	logic        full_grp;
	logic        xfer;
	logic [17:0] buf_nx;
	logic [1:0]  cnt_nx;
	logic [23:0] word;

	// A new character is taken whenever the queue has room.
	assign in_ch.ready = !q_full;
	assign xfer        = in_ch.valid && in_ch.ready;

	// Classify the character and work out the next gather state.
	always_comb begin
		sx       = sextet_of(in_ch.char_code);
		is_pad   = !pad_q && (in_ch.char_code == PAD_CHAR);
		take     = !pad_q && !is_pad && sx.valid;
		full_grp = take && (cnt_q == 2'd3);
		word     = {buf_q[17:0], sx.value};
		buf_nx   = buf_q;
		cnt_nx   = cnt_q;
		if (full_grp) begin
			buf_nx = '0;
			cnt_nx = 2'd0;
		end else if (take) begin
			buf_nx = {buf_q[11:0], sx.value};
			cnt_nx = cnt_q + 2'd1;
		end
	end

	// Build the group that this character causes, if any.
	always_comb begin
		push_data = '0;
		push      = 1'b0;
		if (full_grp) begin
			push_data.bytes   = word;
			push_data.n_bytes = 2'd3;
			push_data.msg_end = in_ch.last_char;
			push              = xfer;
		end else if (in_ch.last_char) begin
			push_data.msg_end = 1'b1;
			push              = xfer;
			case (cnt_nx)
				2'd2: begin
					push_data.bytes[2] = buf_nx[11:4];
					push_data.n_bytes  = 2'd1;
				end
				2'd3: begin
					push_data.bytes[2] = buf_nx[17:10];
					push_data.bytes[1] = buf_nx[9:2];
					push_data.n_bytes  = 2'd2;
				end
				default: push_data.n_bytes = 2'd0;
			endcase
		end
	end

	// Gather state; the end of a message clears it for the next one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= '0;
			cnt_q <= 2'd0;
			pad_q <= 1'b0;
		end else if (xfer) begin
			if (in_ch.last_char) begin
				buf_q <= '0;
				cnt_q <= 2'd0;
				pad_q <= 1'b0;
			end else begin
				buf_q <= buf_nx;
				cnt_q <= cnt_nx;
				pad_q <= pad_q | is_pad;
			end
		end
	end

endmodule

### sv/b64dec_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64dec_queue
// Small register queue of byte groups between front and back.
// ----------------------------------------------------------------------------
module b64dec_queue #(
	parameter int DEPTH = b64dec_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  b64dec_pkg::group_t push_data,
	input  logic               pop,
	output logic               full,
	output logic               not_empty,
	output b64dec_pkg::group_t head
);
	import b64dec_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	group_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### sv/b64dec_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64dec_back
// Takes byte groups from the queue and sends them one result per transfer.
// ----------------------------------------------------------------------------
module b64dec_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_not_empty,
	input  b64dec_pkg::group_t q_head,
	output logic               pop,
	b64dec_byte_if.source      out_ch
);
	import b64dec_pkg::*;

	group_t     cur_q;
	logic       cur_valid_q;
	logic [1:0] idx_q;

	logic [1:0] last_idx;
	logic       at_last;
	logic       xfer;
	logic       load;

	// The empty marker counts as one result.
	assign last_idx = (cur_q.n_bytes == 2'd0) ? 2'd0 : cur_q.n_bytes - 2'd1;
	assign at_last  = (idx_q == last_idx);
	assign xfer     = out_ch.valid && out_ch.ready;
	assign load     = !cur_valid_q || (xfer && at_last);
	assign pop      = load && q_not_empty;

	// Result payload from the held group.
	always_comb begin
		out_ch.valid       = cur_valid_q;
		out_ch.has_data    = (cur_q.n_bytes != 2'd0);
		out_ch.run_last    = at_last;
		out_ch.message_end = at_last && cur_q.msg_end;
		case (idx_q)
			2'd0:    out_ch.data_byte = cur_q.bytes[2];
			2'd1:    out_ch.data_byte = cur_q.bytes[1];
			2'd2:    out_ch.data_byte = cur_q.bytes[0];
			default: out_ch.data_byte = 8'd0;
		endcase
		if (cur_q.n_bytes == 2'd0) begin
			out_ch.data_byte = 8'd0;
		end
	end

	// Group payload register.
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_head;
		end
	end

	// Result index and hold flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (load) begin
			cur_valid_q <= q_not_empty;
			idx_q       <= 2'd0;
		end else if (xfer) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule
